// ===== design/clp_pkg.sv =====
`timescale 1ns / 1ps

package clp_pkg;

   // Width of one partial-product operand chunk.
   localparam int CHUNK_W = 32;

   // Exact widths of the intermediate values.
   localparam int CROSS_W = 65;   // D1 x D2 component
   localparam int TMP_W   = 97;   // D x C component
   localparam int DEN_W   = 130;  // squared cross length
   localparam int DET_W   = 130;  // 3x3 determinant
   localparam int NUM_W   = 162;  // signed numerator of a quotient
   localparam int REM_W   = NUM_W + 1;
   localparam int QUO_W   = 33;   // quotient bits before rounding

   localparam int NUM_LANES = 8;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // One input item: two lines, each coordinate a 32-bit value.
   typedef struct packed {
      logic [2:0][31:0] d2;
      logic [2:0][31:0] o2;
      logic [2:0][31:0] d1;
      logic [2:0][31:0] o1;
   } lines_type;

   // Register stages of one chunked multiplier.
   function automatic int mul_lat(input int aw, input int bw);
      return ((aw + CHUNK_W - 1) / CHUNK_W) * ((bw + CHUNK_W - 1) / CHUNK_W) + 2;
   endfunction

endpackage

// ===== design/clp_mul.sv =====
`timescale 1ns / 1ps

// Signed multiplier built from 32x32 partial products, one per stage.
// Stages: entry, one per chunk product, then sign; all advance only while en is high.
module clp_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [AW-1:0]     a,
   input  logic signed [BW-1:0]     b,
   output logic signed [AW+BW-1:0]  p
);
   import clp_pkg::*;

   localparam int NA  = (AW + CHUNK_W - 1) / CHUNK_W;
   localparam int NB  = (BW + CHUNK_W - 1) / CHUNK_W;
   localparam int NS  = NA * NB;
   localparam int PW  = AW + BW;
   localparam int AXW = NA * CHUNK_W;
   localparam int BXW = NB * CHUNK_W;

   logic [AXW-1:0] ma_ff  [0:NS-1];
   logic [BXW-1:0] mb_ff  [0:NS-1];
   logic           sg_ff  [0:NS];
   logic [PW-1:0]  acc_ff [0:NS];
   logic [PW-1:0]  p_ff;
   logic [AW-1:0]  a_mag;
   logic [BW-1:0]  b_mag;

   // Magnitudes of the operands; the most negative value maps to its power of two.
   assign a_mag = a[AW-1] ? (~a + 1'b1) : a;
   assign b_mag = b[BW-1] ? (~b + 1'b1) : b;

   // Entry stage: magnitudes and product sign.
   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff[0]  <= AXW'(a_mag);
         mb_ff[0]  <= BXW'(b_mag);
         sg_ff[0]  <= a[AW-1] ^ b[BW-1];
         acc_ff[0] <= '0;
      end
   end

   // One chunk product accumulated per stage.
   for (genvar s = 1; s <= NS; s++) begin : g_step
      localparam int I = (s - 1) / NB;
      localparam int J = (s - 1) % NB;
      logic [2*CHUNK_W-1:0] pp;

      assign pp = ma_ff[s-1][I*CHUNK_W +: CHUNK_W] * mb_ff[s-1][J*CHUNK_W +: CHUNK_W];

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[s] <= acc_ff[s-1] + (PW'(pp) << (CHUNK_W * (I + J)));
            sg_ff[s]  <= sg_ff[s-1];
         end
      end

      if (s < NS) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               ma_ff[s] <= ma_ff[s-1];
               mb_ff[s] <= mb_ff[s-1];
            end
         end
      end
   end

   // Apply the sign.
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sg_ff[NS] ? (~acc_ff[NS] + 1'b1) : acc_ff[NS];
      end
   end

   assign p = signed'(p_ff);

endmodule

// ===== design/closest_points_between_lines.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Content
// req_     | in        | tdata: two lines (origin and direction each), 12 x 32 bits
// rsp_     | out       | tdata: t1, P1, t2, P2, 8 x 32 bits; tuser: found
// csr_     | in        | parallel threshold, 31 bits
//
// Fully pipelined: one item is taken every cycle while no result waits in the output
// register. The depth is set by the chunked multipliers and the 33 restoring
// divider stages that run for eight quotients side by side.
// Reset clears all valid bits and sets the threshold to one LSB.
// A result that waits in the output register stalls the whole pipeline; nothing
// moves, so nothing is lost or repeated.
module closest_points_between_lines #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // o1 x,y,z; d1 x,y,z; o2 x,y,z; d2 x,y,z (from bit 0 up)
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // first_param, first_point x,y,z, second_param, second_point x,y,z (from bit 0 up)
   output logic [255:0] rsp_tdata,
   // found
   output logic [0:0]   rsp_tuser,
   input  logic         csr_wen,
   input  logic [30:0]  csr_wdata
);
   import clp_pkg::*;

   localparam int LM1 = mul_lat(32, 32);
   localparam int LM2 = mul_lat(CROSS_W, CROSS_W);
   localparam int LM3 = mul_lat(33, TMP_W);
   localparam int LM4 = mul_lat(DEN_W, 32);
   localparam int SA  = LM1 + 1;          // cross product registered
   localparam int SB  = SA + LM2 + 1;     // den and D x C registered
   localparam int SC  = SB + LM3 + 1;     // determinants registered
   localparam int SD  = SC + LM4 + 1;     // numerators registered
   localparam int NDV = QUO_W + 1;        // last divider stage, relative
   localparam int ST  = SD + NDV + 1;     // last stage before the output

   localparam int NX [3] = '{1, 2, 0};
   localparam int NY [3] = '{2, 0, 1};

   logic                      en;
   lines_type                 bnd_in;
   lines_type                 bnd_ff   [0:SC];
   logic                      v_ff     [0:ST];
   logic                      fnd_ff   [SB+1:ST];
   logic [30:0]               thr_ff;
   logic [DEN_W-1:0]          thr_shift;

   logic signed [31:0]        p1a [6];
   logic signed [31:0]        p1b [6];
   logic signed [63:0]        p1p [6];
   logic signed [CROSS_W-1:0] c_ff [3];

   logic signed [CROSS_W-1:0] p2a [15];
   logic signed [CROSS_W-1:0] p2b [15];
   logic signed [2*CROSS_W-1:0] p2p [15];
   logic signed [DEN_W-1:0]   den_ff [SB:SD+NDV];
   logic signed [TMP_W-1:0]   t1_ff [3];
   logic signed [TMP_W-1:0]   t2_ff [3];

   logic signed [32:0]        p3a [6];
   logic signed [TMP_W-1:0]   p3b [6];
   logic signed [33+TMP_W-1:0] p3p [6];
   logic signed [DET_W-1:0]   det1_ff [SC:SD-1];
   logic signed [DET_W-1:0]   det2_ff [SC:SD-1];

   logic signed [DEN_W-1:0]   p4a [12];
   logic signed [31:0]        p4b [12];
   logic signed [DEN_W+31:0]  p4p [12];
   logic signed [NUM_W-1:0]   num_ff [NUM_LANES];

   logic [NUM_W-1:0]          mag_ff [NUM_LANES];
   logic                      neg_ff [NUM_LANES][0:NDV];
   logic                      sat_ff [NUM_LANES][1:NDV];
   logic [REM_W-1:0]          rem_ff [NUM_LANES][1:NDV];
   logic [QUO_W-1:0]          q_ff   [NUM_LANES][1:NDV];

   logic [31:0]               res    [NUM_LANES];
   logic                      rsp_valid_ff;
   logic [255:0]              rsp_data_ff;
   logic                      rsp_user_ff;

   // Whole pipeline advances unless a result waits in the output register.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 31'd1;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   assign thr_shift = DEN_W'(thr_ff) << (3 * FRAC_BITS);

   // Unpack the item.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bnd_in.o1[i] = req_tdata[32*i +: 32];
         bnd_in.d1[i] = req_tdata[96 + 32*i +: 32];
         bnd_in.o2[i] = req_tdata[192 + 32*i +: 32];
         bnd_in.d2[i] = req_tdata[288 + 32*i +: 32];
      end
   end

   // Valid bits and the line data travel with the item.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ST; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int k = 1; k <= ST; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bnd_ff[0] <= bnd_in;
         for (int k = 1; k <= SC; k++) begin
            bnd_ff[k] <= bnd_ff[k-1];
         end
      end
   end

   // Cross product C = D1 x D2.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1a[2*i]   = signed'(bnd_ff[0].d1[NX[i]]);
         p1b[2*i]   = signed'(bnd_ff[0].d2[NY[i]]);
         p1a[2*i+1] = signed'(bnd_ff[0].d1[NY[i]]);
         p1b[2*i+1] = signed'(bnd_ff[0].d2[NX[i]]);
      end
   end

   for (genvar m = 0; m < 6; m++) begin : g_mul1
      clp_mul #(.AW(32), .BW(32)) u_mul (
         .clock(clock), .en(en), .a(p1a[m]), .b(p1b[m]), .p(p1p[m]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= CROSS_W'(p1p[2*i]) - CROSS_W'(p1p[2*i+1]);
         end
      end
   end

   // Squares of C, D2 x C and D1 x C.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p2a[i]       = c_ff[i];
         p2b[i]       = c_ff[i];
         p2a[3+2*i]   = CROSS_W'(signed'(bnd_ff[SA].d2[NX[i]]));
         p2b[3+2*i]   = c_ff[NY[i]];
         p2a[4+2*i]   = CROSS_W'(signed'(bnd_ff[SA].d2[NY[i]]));
         p2b[4+2*i]   = c_ff[NX[i]];
         p2a[9+2*i]   = CROSS_W'(signed'(bnd_ff[SA].d1[NX[i]]));
         p2b[9+2*i]   = c_ff[NY[i]];
         p2a[10+2*i]  = CROSS_W'(signed'(bnd_ff[SA].d1[NY[i]]));
         p2b[10+2*i]  = c_ff[NX[i]];
      end
   end

   for (genvar m = 0; m < 15; m++) begin : g_mul2
      clp_mul #(.AW(CROSS_W), .BW(CROSS_W)) u_mul (
         .clock(clock), .en(en), .a(p2a[m]), .b(p2b[m]), .p(p2p[m]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[SB] <= DEN_W'(p2p[0] + p2p[1] + p2p[2]);
         for (int i = 0; i < 3; i++) begin
            t1_ff[i] <= TMP_W'(p2p[3+2*i] - p2p[4+2*i]);
            t2_ff[i] <= TMP_W'(p2p[9+2*i] - p2p[10+2*i]);
         end
         for (int k = SB + 1; k <= SD + NDV; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   // Parallel test, then the flag rides along.
   always_ff @(posedge clock) begin
      if (en) begin
         fnd_ff[SB+1] <= unsigned'(den_ff[SB]) > thr_shift;
         for (int k = SB + 2; k <= ST; k++) begin
            fnd_ff[k] <= fnd_ff[k-1];
         end
      end
   end

   // Determinants E . (D2 x C) and E . (D1 x C), E = O2 - O1.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p3a[i]   = 33'(signed'(bnd_ff[SB].o2[i])) - 33'(signed'(bnd_ff[SB].o1[i]));
         p3a[3+i] = p3a[i];
         p3b[i]   = t1_ff[i];
         p3b[3+i] = t2_ff[i];
      end
   end

   for (genvar m = 0; m < 6; m++) begin : g_mul3
      clp_mul #(.AW(33), .BW(TMP_W)) u_mul (
         .clock(clock), .en(en), .a(p3a[m]), .b(p3b[m]), .p(p3p[m]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det1_ff[SC] <= DET_W'(p3p[0] + p3p[1] + p3p[2]);
         det2_ff[SC] <= DET_W'(p3p[3] + p3p[4] + p3p[5]);
         for (int k = SC + 1; k <= SD - 1; k++) begin
            det1_ff[k] <= det1_ff[k-1];
            det2_ff[k] <= det2_ff[k-1];
         end
      end
   end

   // Point numerators O * den + D * det.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p4a[i]   = den_ff[SC];
         p4b[i]   = signed'(bnd_ff[SC].o1[i]);
         p4a[3+i] = det1_ff[SC];
         p4b[3+i] = signed'(bnd_ff[SC].d1[i]);
         p4a[6+i] = den_ff[SC];
         p4b[6+i] = signed'(bnd_ff[SC].o2[i]);
         p4a[9+i] = det2_ff[SC];
         p4b[9+i] = signed'(bnd_ff[SC].d2[i]);
      end
   end

   for (genvar m = 0; m < 12; m++) begin : g_mul4
      clp_mul #(.AW(DEN_W), .BW(32)) u_mul (
         .clock(clock), .en(en), .a(p4a[m]), .b(p4b[m]), .p(p4p[m]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= NUM_W'(det1_ff[SD-1]) <<< FRAC_BITS;
         num_ff[4] <= NUM_W'(det2_ff[SD-1]) <<< FRAC_BITS;
         for (int i = 0; i < 3; i++) begin
            num_ff[1+i] <= NUM_W'(p4p[i]) + NUM_W'(p4p[3+i]);
            num_ff[5+i] <= NUM_W'(p4p[6+i]) + NUM_W'(p4p[9+i]);
         end
      end
   end

   // Eight restoring dividers: magnitude, overflow check, then one quotient bit a stage.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            mag_ff[l]    <= num_ff[l][NUM_W-1] ? (~num_ff[l] + 1'b1) : num_ff[l];
            neg_ff[l][0] <= num_ff[l][NUM_W-1];
            neg_ff[l][1] <= neg_ff[l][0];
            sat_ff[l][1] <= {mag_ff[l], 1'b0} >= (REM_W'(unsigned'(den_ff[SD+1])) << QUO_W);
            rem_ff[l][1] <= {mag_ff[l], 1'b0};
            q_ff[l][1]   <= '0;
            for (int j = 2; j <= NDV; j++) begin
               neg_ff[l][j] <= neg_ff[l][j-1];
               sat_ff[l][j] <= sat_ff[l][j-1];
               if (rem_ff[l][j-1] >= (REM_W'(unsigned'(den_ff[SD+j])) << (NDV - j))) begin
                  rem_ff[l][j] <= rem_ff[l][j-1]
                                  - (REM_W'(unsigned'(den_ff[SD+j])) << (NDV - j));
                  q_ff[l][j]   <= q_ff[l][j-1] | (QUO_W'(1) << (NDV - j));
               end else begin
                  rem_ff[l][j] <= rem_ff[l][j-1];
                  q_ff[l][j]   <= q_ff[l][j-1];
               end
            end
         end
      end
   end

   // Round half away from zero, saturate, and zero the results of parallel lines.
   always_comb begin
      logic [QUO_W:0]   qp;
      logic [QUO_W-1:0] rnd;
      logic             ovf;
      for (int l = 0; l < NUM_LANES; l++) begin
         qp  = {1'b0, q_ff[l][NDV]} + 1'b1;
         rnd = qp[QUO_W:1];
         ovf = sat_ff[l][NDV] ||
               (neg_ff[l][NDV] ? (rnd > QUO_W'(SAT_NEG)) : (rnd > QUO_W'(SAT_POS)));
         if (!fnd_ff[ST]) begin
            res[l] = '0;
         end else if (ovf) begin
            res[l] = neg_ff[l][NDV] ? SAT_NEG : SAT_POS;
         end else if (neg_ff[l][NDV]) begin
            res[l] = ~rnd[31:0] + 1'b1;
         end else begin
            res[l] = rnd[31:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[ST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_user_ff <= fnd_ff[ST];
         for (int l = 0; l < NUM_LANES; l++) begin
            rsp_data_ff[32*l +: 32] <= res[l];
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   // Parallel lines give all-zero results.
   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("parallel result carries nonzero data");

   // A held result freezes the pipeline input.
   a_stall_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while output is stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule
